/* rtl/status_led_sequencer_assert.svh */
// ----------------------------------------------------------------------------
// Status LED sequencer assertion macros
// Concurrent assertion shorthands. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_SEQUENCER_ASSERT_SVH
`define STATUS_LED_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SLS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("status_led_sequencer assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("status_led_sequencer assertion failed");

`else

`define SLS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SLS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/sls_pkg.sv */
// ----------------------------------------------------------------------------
// Status LED sequencer package
// Shared types, command codes and reset constants.
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BLINK_PERIOD   = 2'd0,
      CSR_WARNING_PERIOD = 2'd1,
      CSR_WARNING_TOGGLES = 2'd2,
      CSR_INACTIVE_DUTY  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      FUNC_TICK           = 3'd0,
      FUNC_SET_READY      = 3'd1,
      FUNC_SET_RUNNING    = 3'd2,
      FUNC_SET_ERROR      = 3'd3,
      FUNC_MOTOR_STARTING = 3'd4,
      FUNC_SET_INACTIVE   = 3'd5
   } func_type;

   localparam logic [15:0] BlinkPeriodReset    = 16'd250;
   localparam logic [15:0] WarningPeriodReset  = 16'd50;
   localparam logic [7:0]  WarningTogglesReset = 8'd25;
   localparam logic [7:0]  InactiveDutyReset   = 8'd7;

   typedef struct packed {
      func_type func;
      logic     flag;
   } req_type;

   typedef struct packed {
      logic       run_led;
      logic       fault_led;
      logic       duty_write;
      logic [7:0] duty_value;
      logic       pwm_setup;
      logic       pwm_low_freq;
   } rsp_type;

   typedef struct packed {
      logic [15:0] blink_period_ms;
      logic [15:0] warning_period_ms;
      logic [7:0]  warning_toggles;
      logic [7:0]  inactive_duty;
   } cfg_type;

   typedef struct packed {
      logic [15:0] elapsed;
      logic        running_mode;
      logic        toggle_phase;
      logic        led_pin;
      logic        error_pin;
      logic        motor_starting;
      logic [7:0]  warning_count;
      logic        inactive_mode;
      logic        inactive_phase;
   } state_type;

endpackage

/* rtl/sls_step.sv */
// ----------------------------------------------------------------------------
// Status LED sequencer step logic
// Next state and result for one request, computed from the current state.
// ----------------------------------------------------------------------------
module sls_step (
   input  sls_pkg::state_type cur_state,
   input  sls_pkg::cfg_type   cfg,
   input  sls_pkg::req_type   req,
   output sls_pkg::state_type nxt_state,
   output sls_pkg::rsp_type   rsp
);

   logic [15:0] elapsed_inc;
   logic        slow_step;
   logic        warn_step;

   assign elapsed_inc = cur_state.elapsed + 16'd1;
   assign slow_step   = elapsed_inc > cfg.blink_period_ms;
   assign warn_step   = cur_state.motor_starting && (elapsed_inc > cfg.warning_period_ms);

   always_comb begin
      nxt_state        = cur_state;
      rsp.duty_write   = 1'b0;
      rsp.duty_value   = 8'd0;
      rsp.pwm_setup    = 1'b0;
      rsp.pwm_low_freq = 1'b0;

      case (req.func)
         sls_pkg::FUNC_TICK: begin
            nxt_state.elapsed = elapsed_inc;
            // Both steps test the incremented count, so both may fire together.
            if (slow_step) begin
               if (cur_state.running_mode) begin
                  nxt_state.toggle_phase = ~nxt_state.toggle_phase;
                  nxt_state.led_pin      = nxt_state.toggle_phase;
               end
               if (cur_state.inactive_mode) begin
                  rsp.duty_write           = 1'b1;
                  rsp.duty_value           = cur_state.inactive_phase ? 8'd0 : cfg.inactive_duty;
                  nxt_state.inactive_phase = ~cur_state.inactive_phase;
               end
               nxt_state.elapsed = 16'd0;
            end
            if (warn_step) begin
               if (cur_state.warning_count < cfg.warning_toggles) begin
                  nxt_state.toggle_phase  = ~nxt_state.toggle_phase;
                  nxt_state.led_pin       = nxt_state.toggle_phase;
                  nxt_state.elapsed       = 16'd0;
                  nxt_state.warning_count = cur_state.warning_count + 8'd1;
               end else begin
                  nxt_state.warning_count  = 8'd0;
                  nxt_state.motor_starting = 1'b0;
                  nxt_state.toggle_phase   = 1'b1;
                  nxt_state.led_pin        = 1'b1;
               end
            end
         end
         sls_pkg::FUNC_SET_READY: begin
            nxt_state.running_mode = 1'b0;
            nxt_state.led_pin      = req.flag;
            nxt_state.error_pin    = 1'b0;
         end
         sls_pkg::FUNC_SET_RUNNING: begin
            nxt_state.running_mode = req.flag;
            nxt_state.error_pin    = 1'b0;
         end
         sls_pkg::FUNC_SET_ERROR: begin
            nxt_state.error_pin = req.flag;
            if (req.flag) begin
               nxt_state.running_mode = 1'b0;
               nxt_state.led_pin      = 1'b0;
            end
         end
         sls_pkg::FUNC_MOTOR_STARTING: begin
            nxt_state.motor_starting = 1'b1;
         end
         sls_pkg::FUNC_SET_INACTIVE: begin
            nxt_state.inactive_mode  = req.flag;
            nxt_state.inactive_phase = 1'b0;
            nxt_state.running_mode   = 1'b0;
            nxt_state.error_pin      = 1'b0;
            rsp.pwm_setup            = 1'b1;
            if (req.flag) begin
               // Entering inactive mode drops the LED and cancels any warning.
               rsp.pwm_low_freq         = 1'b0;
               nxt_state.led_pin        = 1'b0;
               nxt_state.warning_count  = 8'd0;
               nxt_state.motor_starting = 1'b0;
            end else begin
               rsp.pwm_low_freq  = 1'b1;
               nxt_state.led_pin = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp.run_led   = nxt_state.led_pin;
      rsp.fault_led = nxt_state.error_pin;
   end

endmodule

/* rtl/status_led_sequencer.sv */
// ----------------------------------------------------------------------------
// Status LED sequencer
// Result: registered in the output register, or in the skid register when the
// output is stalled. One request per cycle while the skid register is empty.
// Reset: synchronous; pins high, modes clear, registers at 250, 50, 25, 7.
// ----------------------------------------------------------------------------
`include "status_led_sequencer_assert.svh"

module status_led_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  sls_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output sls_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wen,
   input  logic [sls_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [sls_pkg::CsrDataWidth-1:0]      csr_wdata
);

   // Config registers. Software is to write them only while the block is idle;
   // the block does not enforce it. Step logic reads them with no shadow copy.
   sls_pkg::cfg_type   cfg_ff;
   sls_pkg::cfg_type   cfg_in;

   // Sequencer state: elapsed counter, mode flags, phases and LED pins.
   sls_pkg::state_type state_ff;
   sls_pkg::state_type state_in;

   // Result of the step logic for the request at the input this cycle.
   sls_pkg::rsp_type   step_rsp;

   // Output register and a skid register behind it. The skid entry lets the
   // block take a request in the very cycle the result side stalls, and the
   // input stall is then raised from a register rather than from rsp_stall.
   logic               out_valid_ff;
   logic               out_valid_in;
   sls_pkg::rsp_type   out_data_ff;
   sls_pkg::rsp_type   out_data_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   sls_pkg::rsp_type   skid_data_ff;
   sls_pkg::rsp_type   skid_data_in;

   logic               req_accept;
   logic               rsp_accept;
   logic               out_free;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_accept = out_valid_ff && !rsp_stall;

   // The output register can take new data when it is empty or being drained.
   assign out_free   = !out_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------------
   // Step logic: the whole update for one request is a short combinational
   // pass from the current state to the next state and the result.
   // ------------------------------------------------------------------------
   sls_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .req       (req_data),
      .nxt_state (state_in),
      .rsp       (step_rsp)
   );

   // ------------------------------------------------------------------------
   // Configuration writes. An index names one register; the write data is
   // truncated to the width of that register.
   // ------------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (sls_pkg::csr_index_type'(csr_index))
            sls_pkg::CSR_BLINK_PERIOD:    cfg_in.blink_period_ms   = csr_wdata;
            sls_pkg::CSR_WARNING_PERIOD:  cfg_in.warning_period_ms = csr_wdata;
            sls_pkg::CSR_WARNING_TOGGLES: cfg_in.warning_toggles   = csr_wdata[7:0];
            sls_pkg::CSR_INACTIVE_DUTY:   cfg_in.inactive_duty     = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period_ms   <= sls_pkg::BlinkPeriodReset;
         cfg_ff.warning_period_ms <= sls_pkg::WarningPeriodReset;
         cfg_ff.warning_toggles   <= sls_pkg::WarningTogglesReset;
         cfg_ff.inactive_duty     <= sls_pkg::InactiveDutyReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------------
   // State register. It moves only when a request is accepted, so every
   // request sees exactly the state that the one before it left behind.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.elapsed        <= 16'd0;
         state_ff.running_mode   <= 1'b0;
         state_ff.toggle_phase   <= 1'b0;
         state_ff.led_pin        <= 1'b1;
         state_ff.error_pin      <= 1'b1;
         state_ff.motor_starting <= 1'b0;
         state_ff.warning_count  <= 8'd0;
         state_ff.inactive_mode  <= 1'b0;
         state_ff.inactive_phase <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result path. Order is kept: a skid entry always holds a result that is
   // younger than the one in the output register, and it moves forward as
   // soon as the output register drains.
   // ------------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;

      if (rsp_accept) begin
         out_valid_in = 1'b0;
      end

      if (skid_valid_ff) begin
         // No request is taken while the skid holds data.
         if (out_free) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = step_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // The skid entry is only ever filled behind an occupied output register.
   `SLS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)

   // A request taken while the output is held back must land in the skid.
   `SLS_ASSERT_NEXT(a_stalled_accept_skids, clock, reset,
      req_accept && out_valid_ff && rsp_stall, skid_valid_ff)

   // A result without a duty write always reports a zero duty.
   `SLS_ASSERT_SAME(a_duty_zero_when_idle, clock, reset,
      out_valid_ff && !out_data_ff.duty_write, out_data_ff.duty_value == 8'd0)

   // A result without a PWM setup never selects the low frequency.
   `SLS_ASSERT_SAME(a_pwm_low_needs_setup, clock, reset,
      out_valid_ff && !out_data_ff.pwm_setup, !out_data_ff.pwm_low_freq)

endmodule

/* tb/sv/status_led_sequencer_tb_pkg.sv */
// ----------------------------------------------------------------------------
// Status LED sequencer scoreboard
// Tracks the sequencer's mode flags, blink and warning state, and the
// registers. It predicts the pin levels, duty write and PWM setup that each
// accepted request should produce, and checks responses against them in order.
// ----------------------------------------------------------------------------
package sls_tb_pkg;

   import sls_pkg::*;

   class led_pin_scoreboard;

      cfg_type   regs;
      state_type st;
      rsp_type   expected_pins[$];
      int unsigned fails;

      function new();
         regs.blink_period_ms   = BlinkPeriodReset;
         regs.warning_period_ms = WarningPeriodReset;
         regs.warning_toggles   = WarningTogglesReset;
         regs.inactive_duty     = InactiveDutyReset;
         st = '0;
         st.led_pin   = 1'b1;
         st.error_pin = 1'b1;
         fails = 0;
      endfunction

      function int unsigned pending();
         return expected_pins.size();
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_BLINK_PERIOD:    regs.blink_period_ms   = value;
            CSR_WARNING_PERIOD:  regs.warning_period_ms = value;
            CSR_WARNING_TOGGLES: regs.warning_toggles   = value[7:0];
            CSR_INACTIVE_DUTY:   regs.inactive_duty     = value[7:0];
            default: ;
         endcase
      endfunction

      // An error indication also leaves running mode and turns the LED off.
      function void apply_error(logic on);
         st.error_pin = on;
         if (on) begin
            st.running_mode = 1'b0;
            st.led_pin      = 1'b0;
         end
      endfunction

      function void apply_ready(logic on);
         st.running_mode = 1'b0;
         st.led_pin      = on;
         apply_error(1'b0);
      endfunction

      function void apply_running(logic on);
         st.running_mode = on;
         apply_error(1'b0);
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         logic [15:0] count;
         e = '0;
         case (r.func)
            FUNC_TICK: begin
               st.elapsed = st.elapsed + 16'd1;
               count = st.elapsed;
               // Both steps compare against the count from before any restart.
               if (count > regs.blink_period_ms) begin
                  if (st.running_mode) begin
                     st.toggle_phase = !st.toggle_phase;
                     st.led_pin      = st.toggle_phase;
                  end
                  if (st.inactive_mode) begin
                     e.duty_write = 1'b1;
                     e.duty_value = st.inactive_phase ? 8'd0 : regs.inactive_duty;
                     st.inactive_phase = !st.inactive_phase;
                  end
                  st.elapsed = '0;
               end
               if (st.motor_starting && count > regs.warning_period_ms) begin
                  if (st.warning_count < regs.warning_toggles) begin
                     st.toggle_phase  = !st.toggle_phase;
                     st.led_pin       = st.toggle_phase;
                     st.elapsed       = '0;
                     st.warning_count = st.warning_count + 8'd1;
                  end else begin
                     st.warning_count  = '0;
                     st.motor_starting = 1'b0;
                     st.toggle_phase   = 1'b1;
                     st.led_pin        = 1'b1;
                  end
               end
            end
            FUNC_SET_READY:      apply_ready(r.flag);
            FUNC_SET_RUNNING:    apply_running(r.flag);
            FUNC_SET_ERROR:      apply_error(r.flag);
            FUNC_MOTOR_STARTING: st.motor_starting = 1'b1;
            FUNC_SET_INACTIVE: begin
               st.inactive_mode  = r.flag;
               st.inactive_phase = 1'b0;
               e.pwm_setup       = 1'b1;
               if (r.flag) begin
                  apply_ready(1'b0);
                  apply_running(1'b0);
                  st.warning_count  = '0;
                  st.motor_starting = 1'b0;
               end else begin
                  e.pwm_low_freq = 1'b1;
                  apply_ready(1'b1);
               end
            end
            default: ;
         endcase
         e.run_led   = st.led_pin;
         e.fault_led = st.error_pin;
         expected_pins.push_back(e);
      endfunction

      task report(string line);
         $display("[%0t] mismatch: %s", $realtime, line);
         fails++;
      endtask

      task check_response(rsp_type got);
         rsp_type exp;
         if (expected_pins.size() == 0) begin
            report($sformatf("response %h with no request outstanding", got));
            return;
         end
         exp = expected_pins.pop_front();
         if (got.run_led !== exp.run_led)
            report($sformatf("run_led %b, expected %b", got.run_led, exp.run_led));
         if (got.fault_led !== exp.fault_led)
            report($sformatf("fault_led %b, expected %b", got.fault_led, exp.fault_led));
         if (got.duty_write !== exp.duty_write)
            report($sformatf("duty_write %b, expected %b", got.duty_write, exp.duty_write));
         if (got.duty_value !== exp.duty_value)
            report($sformatf("duty_value %0d, expected %0d", got.duty_value, exp.duty_value));
         if (got.pwm_setup !== exp.pwm_setup)
            report($sformatf("pwm_setup %b, expected %b", got.pwm_setup, exp.pwm_setup));
         if (got.pwm_low_freq !== exp.pwm_low_freq)
            report($sformatf("pwm_low_freq %b, expected %b", got.pwm_low_freq,
                             exp.pwm_low_freq));
      endtask

   endclass

endpackage

/* tb/sv/status_led_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// Status LED sequencer testbench
// Drives ticks and commands into the sequencer in random bursts while the
// response side stalls on its own changing pattern. A scoreboard predicts each
// response from the accepted requests and checks every field in order. The
// run walks through several register settings, extremes included.
// ----------------------------------------------------------------------------
module status_led_sequencer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sls_pkg::*;
   import sls_tb_pkg::*;

   // Response stall patterns; each one holds for a random number of cycles.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_EVERY_THIRD
   } stall_pattern_type;

   localparam int unsigned RandomPhases    = 10;
   localparam int unsigned PhaseRequests   = 190;
   localparam int unsigned LongHoldCycles  = 80;
   localparam int unsigned PressureBurst   = 30;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wen = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   led_pin_scoreboard sb = new();

   // Sender burst bookkeeping. While steady_send is set, no gaps are inserted.
   int unsigned burst_left  = 0;
   bit          steady_send = 1'b0;

   // The main sequence raises hold_request; the stall process then counts out
   // a long hold on its own and clears the request.
   bit                hold_request = 1'b0;
   int unsigned       hold_left    = 0;
   stall_pattern_type pattern      = STALL_NONE;
   int unsigned       pattern_left = 0;
   int unsigned       pattern_step = 0;

   status_led_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Everything is sampled at the rising edge, before the edge's own updates
   // land, so a request, a response and a register write are each seen once.
   // Requests are noted before responses are checked; the response queue is
   // in order, so a response always matches the oldest outstanding request.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) begin
            sb.write_register(csr_index_type'(csr_index), csr_wdata);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
         end
      end
   end

   // Response stall generator. A long hold takes priority over the pattern.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LongHoldCycles - 1;
         rsp_stall    <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern      = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 150);
         end
         pattern_left--;
         pattern_step++;
         case (pattern)
            STALL_NONE:        rsp_stall <= 1'b0;
            STALL_LIGHT:       rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:       rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_EVERY_THIRD: rsp_stall <= (pattern_step % 3 == 0);
            default:           rsp_stall <= 1'b0;
         endcase
      end
   end

   // Offers one request and returns at the edge that accepts it. Each call
   // starts right after a rising edge. A new burst may open with a gap of
   // idle cycles; long gapless bursts give stretches with no idling.
   task automatic send_request(input func_type func, input logic flag);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 2);
         if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap        = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
         end
         if (gap != 0 && !steady_send) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data.func <= func;
      req_data.flag <= flag;
      do @(posedge clock); while (req_stall);
   endtask

   // Draws one random request. Ticks dominate so that blinking, warnings and
   // inactive pulsing actually advance; running is mostly switched on so the
   // slow blink gets exercised. Codes six and seven show up as noise.
   task automatic send_random_request();
      int unsigned pick;
      func_type    func;
      logic        flag;
      pick = $urandom_range(0, 99);
      flag = 1'($urandom_range(0, 1));
      if (pick < 62) begin
         func = FUNC_TICK;
      end else if (pick < 70) begin
         func = FUNC_MOTOR_STARTING;
      end else if (pick < 77) begin
         func = FUNC_SET_RUNNING;
         flag = ($urandom_range(0, 3) != 0);
      end else if (pick < 83) begin
         func = FUNC_SET_READY;
      end else if (pick < 88) begin
         func = FUNC_SET_ERROR;
      end else if (pick < 95) begin
         func = FUNC_SET_INACTIVE;
      end else begin
         func = func_type'($urandom_range(6, 7));
      end
      send_request(func, flag);
   endtask

   // Stops offering and waits until every outstanding response is back, then
   // lets the output and skid registers settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all four registers back to back. The upper byte of the 8-bit
   // registers carries random junk, which the block must ignore.
   task automatic program_registers(input logic [15:0] blink, input logic [15:0] warn,
                                    input logic [7:0] toggles, input logic [7:0] duty);
      write_register(CSR_BLINK_PERIOD, blink);
      write_register(CSR_WARNING_PERIOD, warn);
      write_register(CSR_WARNING_TOGGLES, {8'($urandom_range(0, 255)), toggles});
      write_register(CSR_INACTIVE_DUTY, {8'($urandom_range(0, 255)), duty});
      csr_wen <= 1'b0;
   endtask

   initial begin
      int unsigned guard;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Unused function codes against the reset state: pins stay high.
      send_request(func_type'(3'd7), 1'b1);
      send_request(func_type'(3'd6), 1'b0);
      wait_for_idle();

      // Directed pass with short periods and full inactive duty.
      program_registers(16'd2, 16'd1, 8'd2, 8'd255);
      send_request(FUNC_SET_ERROR, 1'b1);
      send_request(FUNC_SET_ERROR, 1'b0);
      send_request(FUNC_SET_READY, 1'b1);
      send_request(FUNC_SET_READY, 1'b0);
      send_request(FUNC_SET_RUNNING, 1'b1);
      // Slow blink: the LED toggles on the tick that exceeds the period.
      repeat (4) send_request(FUNC_TICK, 1'b1);
      // Warning: fast toggles while running until the toggle count is reached,
      // then the LED is set on and the slow blink takes over again.
      send_request(FUNC_MOTOR_STARTING, 1'b0);
      for (int i = 0; i < 6; i++) send_request(FUNC_TICK, 1'(i));
      // Inactive pulsing alternates between full duty and zero.
      send_request(FUNC_SET_INACTIVE, 1'b1);
      repeat (3) send_request(FUNC_TICK, 1'b0);
      send_request(FUNC_SET_INACTIVE, 1'b0);
      wait_for_idle();

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: program_registers(16'd1, 16'd1, 8'd1, 8'd0);
            1: program_registers(16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
            // All registers at zero: every tick steps and warnings end at once.
            2: program_registers(16'd0, 16'd0, 8'd0, 8'd0);
            default: begin
               program_registers(($urandom_range(0, 4) == 0) ? 16'($urandom_range(11, 300))
                                                             : 16'($urandom_range(1, 10)),
                                 16'($urandom_range(1, 5)), 8'($urandom_range(1, 6)),
                                 8'($urandom_range(0, 255)));
            end
         endcase

         // Once, hold the response side off for a long stretch while requests
         // keep coming, so the block backs up and stalls its input.
         if (phase == 4) begin
            hold_request = 1'b1;
            steady_send  = 1'b1;
            repeat (PressureBurst) send_random_request();
            steady_send  = 1'b0;
         end

         repeat (PhaseRequests) send_random_request();
         wait_for_idle();
      end

      // Wait out whatever is still in flight, with a bound, then let the
      // pipeline settle so a stray extra response would still be caught.
      req_valid <= 1'b0;
      for (guard = 0; guard < 2000 && sb.pending() != 0; guard++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected responses never arrived", sb.pending()));
      end
      if (sb.fails == 0) begin
         $display("status_led_sequencer_tb passed");
      end else begin
         $display("status_led_sequencer_tb failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of roughly 1950 requests.
   initial begin
      #5_000_000;
      $display("status_led_sequencer_tb failed");
      $finish;
   end

endmodule
